// ===== rtl/tts_pkg.sv =====
// shared types and constants of the tick task scheduler table
`default_nettype none

package tts_pkg;

    // field widths of the transfer payloads
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 8;
    localparam int TAG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int RUNS_W   = 8;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int ERR_W    = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NODEL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE  = 3'd4;

    // sticky error codes
    localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NODEL    = 2'd2;

    // saturation value of the pending run count
    localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

    // one slot as kept in the slot memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [RUNS_W-1:0] runs;
    } slot_entry_t;

    // one result as held in the output register
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    tag;
        logic [STATUS_W-1:0] status;
        logic [ERR_W-1:0]    err;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tick_task_scheduler_table_core.sv =====
// Cooperative time-triggered task scheduler table, top level.
//
// Input channel (in_valid/in_ready) takes one operation per transfer: add a
// task, delete a slot, tick, or dispatch. Output channel (out_valid/out_ready)
// gives the results; last marks the final result of one input operation.
// Add and delete finish in the accept cycle; their single result shows on the
// next cycle. Tick and dispatch sweep the slot memory one slot per cycle; a
// dispatch sweep keeps that rate only while the receiver keeps up.
// The sweep is set by the one read port and one write port of the slot memory.
// Dispatch gives one result per slot with pending runs, in slot order, or one
// "nothing ready" result; one result is held back until the next one or the
// end of the sweep is known, so that last can be set.
// A new operation is taken only when the previous one is finished and the
// output register is free or being drained. When the receiver stalls, the
// output register holds its result and the dispatch sweep pauses.
// Reset clears all valid marks and the sticky error at once; the slot memory
// needs no clearing pass, since a slot without its valid mark reads as zero.
`default_nettype none

module tick_task_scheduler_table_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tts_pkg::FUNC_W-1:0]      func,
    input  wire logic [tts_pkg::IDX_W-1:0]       slot_index,
    input  wire logic [tts_pkg::TAG_W-1:0]       task_tag,
    input  wire logic [tts_pkg::TIME_W-1:0]      first_delay,
    input  wire logic [tts_pkg::TIME_W-1:0]      repeat_period,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [tts_pkg::SLOT_W-1:0]           result_slot,
    output logic [tts_pkg::TAG_W-1:0]            result_tag,
    output logic [tts_pkg::STATUS_W-1:0]         status,
    output logic [tts_pkg::ERR_W-1:0]            sticky_err,
    output logic                                 last
);
    import tts_pkg::*;

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [SLOT_W-1:0] NO_SLOT  = SLOT_W'(MAX_TASKS);
    localparam logic [CW-1:0]     SCAN_END = CW'(MAX_TASKS);
    localparam logic [IDX_W-1:0]  IDX_LIM  = IDX_W'(MAX_TASKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic [AW-1:0]        eval_idx_reg, eval_idx_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [AW-1:0]        hold_slot_reg, hold_slot_next;
    logic [TAG_W-1:0]     hold_tag_reg, hold_tag_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg, out_res_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    slot_entry_t          mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    slot_entry_t          mem_rdata;

    logic                 free_found;
    logic [AW-1:0]        free_idx;

    logic                 out_free;
    logic                 advance;
    logic                 del_ok;
    slot_entry_t          cur_entry;

    tts_slot_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tts_free_find #(
        .N  (MAX_TASKS),
        .AW (AW)
    ) u_find (
        .valid (valid_reg),
        .found (free_found),
        .index (free_idx)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;

    // slot under evaluation; a slot without valid mark reads as all zero
    assign cur_entry = valid_reg[eval_idx_reg] ? mem_rdata : '0;

    // delete check, bound first
    assign del_ok = (slot_index < IDX_LIM) && valid_reg[slot_index[AW-1:0]];

    // sequencer and datapath next-state logic
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        scan_idx_next   = scan_idx_reg;
        eval_idx_next   = eval_idx_reg;
        valid_next      = valid_reg;
        err_next        = err_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_tag_next   = hold_tag_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        mem_we          = 1'b0;
        mem_waddr       = eval_idx_reg;
        mem_wdata       = cur_entry;
        mem_re          = 1'b0;
        mem_raddr       = scan_idx_reg[AW-1:0];
        advance         = 1'b1;

        // output register drained
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (op_t'(func))
                        OP_ADD:
                        begin
                            out_valid_next   = 1'b1;
                            out_res_next.tag = '0;
                            out_res_next.last = 1'b1;
                            if (free_found)
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = free_idx;
                                mem_wdata.tag        = task_tag;
                                mem_wdata.delay      = first_delay;
                                mem_wdata.period     = repeat_period;
                                mem_wdata.runs       = '0;
                                valid_next[free_idx] = 1'b1;
                                out_res_next.slot    = SLOT_W'(free_idx);
                                out_res_next.status  = ST_DONE;
                                out_res_next.err     = err_reg;
                            end
                            else
                            begin
                                err_next            = ERR_TOO_MANY;
                                out_res_next.slot   = NO_SLOT;
                                out_res_next.status = ST_FULL;
                                out_res_next.err    = ERR_TOO_MANY;
                            end
                        end
                        OP_DELETE:
                        begin
                            out_valid_next    = 1'b1;
                            out_res_next.tag  = '0;
                            out_res_next.last = 1'b1;
                            if (del_ok)
                            begin
                                valid_next[slot_index[AW-1:0]] = 1'b0;
                                out_res_next.slot   = SLOT_W'(slot_index);
                                out_res_next.status = ST_DONE;
                                out_res_next.err    = err_reg;
                            end
                            else
                            begin
                                err_next            = ERR_NODEL;
                                out_res_next.slot   = NO_SLOT;
                                out_res_next.status = ST_NODEL;
                                out_res_next.err    = ERR_NODEL;
                            end
                        end
                        OP_TICK, OP_DISPATCH:
                        begin
                            mem_re          = 1'b1;
                            mem_raddr       = '0;
                            eval_idx_next   = '0;
                            scan_idx_next   = CW'(1);
                            op_next         = op_t'(func);
                            hold_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (op_reg == OP_TICK)
                begin
                    // timing update of one valid slot
                    if (valid_reg[eval_idx_reg])
                    begin
                        mem_we = 1'b1;
                        if (cur_entry.delay == '0)
                        begin
                            if (cur_entry.runs != RUNS_MAX)
                            begin
                                mem_wdata.runs = cur_entry.runs + 1'b1;
                            end
                            if (cur_entry.period != '0)
                            begin
                                mem_wdata.delay = cur_entry.period;
                            end
                        end
                        else
                        begin
                            mem_wdata.delay = cur_entry.delay - 1'b1;
                        end
                    end
                end
                else if (cur_entry.runs != '0)
                begin
                    // dispatch; wait while the held result cannot move on
                    if (hold_valid_reg && !out_free)
                    begin
                        advance = 1'b0;
                    end
                    else
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next      = 1'b1;
                            out_res_next.slot   = SLOT_W'(hold_slot_reg);
                            out_res_next.tag    = hold_tag_reg;
                            out_res_next.status = ST_RUN;
                            out_res_next.err    = err_reg;
                            out_res_next.last   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = eval_idx_reg;
                        hold_tag_next   = cur_entry.tag;
                        if (cur_entry.period == '0)
                        begin
                            valid_next[eval_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.runs = cur_entry.runs - 1'b1;
                        end
                    end
                end

                // step to the next slot
                if (advance)
                begin
                    if (scan_idx_reg == SCAN_END)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        eval_idx_next = scan_idx_reg[AW-1:0];
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            S_FLUSH:
            begin
                // final result of the sweep
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_res_next.err  = err_reg;
                    out_res_next.last = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        out_res_next.slot   = NO_SLOT;
                        out_res_next.tag    = '0;
                        out_res_next.status = ST_DONE;
                    end
                    else if (hold_valid_reg)
                    begin
                        out_res_next.slot   = SLOT_W'(hold_slot_reg);
                        out_res_next.tag    = hold_tag_reg;
                        out_res_next.status = ST_RUN;
                    end
                    else
                    begin
                        out_res_next.slot   = NO_SLOT;
                        out_res_next.tag    = '0;
                        out_res_next.status = ST_IDLE;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_TICK;
            scan_idx_reg   <= '0;
            eval_idx_reg   <= '0;
            valid_reg      <= '0;
            err_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            scan_idx_reg   <= scan_idx_next;
            eval_idx_reg   <= eval_idx_next;
            valid_reg      <= valid_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_slot_reg <= hold_slot_next;
        hold_tag_reg  <= hold_tag_next;
        out_res_reg   <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_slot = out_res_reg.slot;
    assign result_tag  = out_res_reg.tag;
    assign status      = out_res_reg.status;
    assign sticky_err  = out_res_reg.err;
    assign last        = out_res_reg.last;

endmodule

`default_nettype wire

// ===== rtl/tts_slot_mem.sv =====
// slot memory: one write port, one registered read port
`default_nettype none

module tts_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire tts_pkg::slot_entry_t wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output tts_pkg::slot_entry_t      rdata
);
    import tts_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tts_free_find.sv =====
// lowest free slot search over the valid marks
`default_nettype none

module tts_free_find #(
    parameter int N  = 16,
    parameter int AW = 4
) (
    input  wire logic [N-1:0]  valid,
    output logic               found,
    output logic [AW-1:0]      index
);

    // priority encoder, lowest clear mark wins
    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                found = 1'b1;
                index = AW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tts_checker.sv =====
// port-level checks of the scheduler table, bound to the top level
`default_nettype none

module tts_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic [tts_pkg::FUNC_W-1:0]      func,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [tts_pkg::SLOT_W-1:0]      result_slot,
    input wire logic [tts_pkg::TAG_W-1:0]       result_tag,
    input wire logic [tts_pkg::STATUS_W-1:0]    status,
    input wire logic [tts_pkg::ERR_W-1:0]       sticky_err,
    input wire logic                            last
);
    import tts_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_slot)
            && $stable(result_tag) && $stable(status) && $stable(last))
    else $error("stalled result changed");

    // add and delete give their single result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == OP_ADD || func == OP_DELETE)
            |=> out_valid && last && status != ST_RUN)
    else $error("add or delete result missing");

    // full table reports the matching sticky error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> sticky_err == ERR_TOO_MANY)
    else $error("full table without sticky error");

    // failed delete reports the matching sticky error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NODEL |-> sticky_err == ERR_NODEL)
    else $error("failed delete without sticky error");

    // only task runs carry a tag or come in a series
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_RUN |-> last && result_tag == '0)
    else $error("non-run result not single or tagged");

endmodule

bind tick_task_scheduler_table_core tts_checker u_tts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_slot (result_slot),
    .result_tag  (result_tag),
    .status      (status),
    .sticky_err  (sticky_err),
    .last        (last)
);

`default_nettype wire

// ===== tb/sv/tick_task_scheduler_table_checker.sv =====
// slot table predictor and result checker of the tick task scheduler table
`timescale 1ns / 100ps

module tick_task_scheduler_table_checker #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [tts_pkg::FUNC_W-1:0]   func,
    input  wire logic [tts_pkg::IDX_W-1:0]    slot_index,
    input  wire logic [tts_pkg::TAG_W-1:0]    task_tag,
    input  wire logic [tts_pkg::TIME_W-1:0]   first_delay,
    input  wire logic [tts_pkg::TIME_W-1:0]   repeat_period,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [tts_pkg::SLOT_W-1:0]   result_slot,
    input  wire logic [tts_pkg::TAG_W-1:0]    result_tag,
    input  wire logic [tts_pkg::STATUS_W-1:0] status,
    input  wire logic [tts_pkg::ERR_W-1:0]    sticky_err,
    input  wire logic                         last,
    output int                                fail_count,
    output int                                outcomes_left
);
    import tts_pkg::*;

    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(MAX_TASKS);

    // shadow copy of the slot table
    logic              tbl_valid  [MAX_TASKS];
    logic [TAG_W-1:0]  tbl_tag    [MAX_TASKS];
    logic [TIME_W-1:0] tbl_delay  [MAX_TASKS];
    logic [TIME_W-1:0] tbl_period [MAX_TASKS];
    logic [RUNS_W-1:0] tbl_runs   [MAX_TASKS];
    logic [ERR_W-1:0]  tbl_error;

    // results owed by the block, oldest first
    result_t sched_outcomes[$];

    function automatic void free_slot(int s);
        tbl_valid[s]  = 1'b0;
        tbl_tag[s]    = '0;
        tbl_delay[s]  = '0;
        tbl_period[s] = '0;
        tbl_runs[s]   = '0;
    endfunction

    function automatic void post_outcome(logic [SLOT_W-1:0] s, logic [TAG_W-1:0] tag,
                                         logic [STATUS_W-1:0] st);
        result_t r;
        r.slot   = s;
        r.tag    = tag;
        r.status = st;
        r.err    = tbl_error;
        r.last   = 1'b0;
        sched_outcomes.push_back(r);
    endfunction

    function automatic string show(result_t r);
        return $sformatf("slot %0d tag %h status %0d error %0d last %0b",
                         r.slot, r.tag, r.status, r.err, r.last);
    endfunction

    // apply one operation to the shadow table and queue its results
    function automatic void schedule_step(op_t op, logic [IDX_W-1:0] idx,
                                          logic [TAG_W-1:0] tag,
                                          logic [TIME_W-1:0] dly,
                                          logic [TIME_W-1:0] per);
        int s;
        int n_before;
        result_t r;
        n_before = sched_outcomes.size();
        case (op)
            OP_ADD: begin
                s = 0;
                while (s < MAX_TASKS && tbl_valid[s])
                    s++;
                if (s >= MAX_TASKS) begin
                    tbl_error = ERR_TOO_MANY;
                    post_outcome(NO_SLOT, '0, ST_FULL);
                end else begin
                    tbl_valid[s]  = 1'b1;
                    tbl_tag[s]    = tag;
                    tbl_delay[s]  = dly;
                    tbl_period[s] = per;
                    tbl_runs[s]   = '0;
                    post_outcome(SLOT_W'(s), '0, ST_DONE);
                end
            end
            OP_DELETE: begin
                if (idx >= MAX_TASKS || !tbl_valid[idx]) begin
                    tbl_error = ERR_NODEL;
                    post_outcome(NO_SLOT, '0, ST_NODEL);
                end else begin
                    free_slot(int'(idx));
                    post_outcome(SLOT_W'(idx), '0, ST_DONE);
                end
            end
            OP_TICK: begin
                for (s = 0; s < MAX_TASKS; s++) begin
                    if (tbl_valid[s]) begin
                        if (tbl_delay[s] == '0) begin
                            if (tbl_runs[s] != RUNS_MAX)
                                tbl_runs[s] = tbl_runs[s] + 1'b1;
                            if (tbl_period[s] != '0)
                                tbl_delay[s] = tbl_period[s];
                        end else begin
                            tbl_delay[s] = tbl_delay[s] - 1'b1;
                        end
                    end
                end
                post_outcome(NO_SLOT, '0, ST_DONE);
            end
            default: begin
                for (s = 0; s < MAX_TASKS; s++) begin
                    if (tbl_runs[s] != '0) begin
                        post_outcome(SLOT_W'(s), tbl_tag[s], ST_RUN);
                        tbl_runs[s] = tbl_runs[s] - 1'b1;
                        // one-shot tasks leave the table once run
                        if (tbl_period[s] == '0)
                            free_slot(s);
                    end
                end
                if (sched_outcomes.size() == n_before)
                    post_outcome(NO_SLOT, '0, ST_IDLE);
            end
        endcase
        // flag the final result of this operation
        r = sched_outcomes.pop_back();
        r.last = 1'b1;
        sched_outcomes.push_back(r);
    endfunction

    // watch both channels: results first, since none can belong to this edge's input
    always @(posedge clk or negedge rst_n) begin : watch
        result_t got;
        result_t want;
        if (!rst_n) begin
            sched_outcomes.delete();
            for (int s = 0; s < MAX_TASKS; s++)
                free_slot(s);
            tbl_error = '0;
            fail_count <= 0;
            outcomes_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = {result_slot, result_tag, status, sticky_err, last};
                if (sched_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %s", $time, show(got));
                    fail_count <= fail_count + 1;
                end else begin
                    want = sched_outcomes.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch, expected %s, got %s",
                                 $time, show(want), show(got));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                schedule_step(op_t'(func), slot_index, task_tag, first_delay, repeat_period);
            outcomes_left <= sched_outcomes.size();
        end
    end

endmodule

// ===== tb/sv/tick_task_scheduler_table_core_tb.sv =====
// stimulus, handshake pacing and verdict for the tick task scheduler table
`timescale 1ns / 100ps

module tick_task_scheduler_table_core_tb;
    import tts_pkg::*;

    localparam int MAX_TASKS      = 16;
    localparam int RANDOM_OPS     = 140;
    localparam int SATURATE_TICKS = 258;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 2 * MAX_TASKS + 8;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    slot_index;
    logic [TAG_W-1:0]    task_tag;
    logic [TIME_W-1:0]   first_delay;
    logic [TIME_W-1:0]   repeat_period;
    logic                out_valid;
    logic                out_ready;
    logic [SLOT_W-1:0]   result_slot;
    logic [TAG_W-1:0]    result_tag;
    logic [STATUS_W-1:0] status;
    logic [ERR_W-1:0]    sticky_err;
    logic                last;

    int fail_count;
    int outcomes_left;
    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_req;
    int quiet_cycles;

    tick_task_scheduler_table_core #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .slot_index(slot_index),
        .task_tag(task_tag),
        .first_delay(first_delay),
        .repeat_period(repeat_period),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_slot(result_slot),
        .result_tag(result_tag),
        .status(status),
        .sticky_err(sticky_err),
        .last(last)
    );

    tick_task_scheduler_table_checker #(
        .MAX_TASKS(MAX_TASKS)
    ) result_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .slot_index(slot_index),
        .task_tag(task_tag),
        .first_delay(first_delay),
        .repeat_period(repeat_period),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_slot(result_slot),
        .result_tag(result_tag),
        .status(status),
        .sticky_err(sticky_err),
        .last(last),
        .fail_count(fail_count),
        .outcomes_left(outcomes_left)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // offer one operation, with random idle cycles ahead of it
    task automatic offer_op(op_t op, logic [IDX_W-1:0] idx, logic [TAG_W-1:0] tag,
                            logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= op;
        slot_index    <= idx;
        task_tag      <= tag;
        first_delay   <= dly;
        repeat_period <= per;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold the input until every owed result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcomes_left != 0)
            @(posedge clk);
    endtask

    // mostly short times so tasks fire, sometimes any 32-bit value
    function automatic logic [TIME_W-1:0] pick_time();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return TIME_W'($urandom_range(3));
        else if (roll < 90)
            return TIME_W'($urandom_range(20));
        else
            return TIME_W'($urandom);
    endfunction

    // one random operation, weighted toward adds and ticks
    task automatic offer_random_op();
        int pick;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            idx = IDX_W'($urandom);
        else
            idx = IDX_W'($urandom_range(MAX_TASKS - 1));
        if (pick < 30)
            offer_op(OP_ADD, IDX_W'($urandom), TAG_W'($urandom), pick_time(), pick_time());
        else if (pick < 50)
            offer_op(OP_DELETE, idx, TAG_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
        else if (pick < 80)
            offer_op(OP_TICK, IDX_W'($urandom), TAG_W'($urandom), TIME_W'($urandom),
                     TIME_W'($urandom));
        else
            offer_op(OP_DISPATCH, IDX_W'($urandom), TAG_W'($urandom), TIME_W'($urandom),
                     TIME_W'($urandom));
    endtask

    // stimulus and verdict
    initial
    begin
        int i;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= OP_TICK;
        slot_index    <= '0;
        task_tag      <= '0;
        first_delay   <= '0;
        repeat_period <= '0;
        long_hold_req = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 52;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: tick, nothing ready, deletes out of range
        offer_op(OP_TICK, '0, '0, '0, '0);
        offer_op(OP_DISPATCH, '0, '0, '0, '0);
        offer_op(OP_DELETE, IDX_W'(MAX_TASKS), '0, '0, '0);
        offer_op(OP_DELETE, '1, '0, '0, '0);
        // one-shot task with tag zero gains a run on every tick
        offer_op(OP_ADD, '0, '0, '0, '0);
        offer_op(OP_TICK, '0, '0, '0, '0);
        offer_op(OP_TICK, '0, '0, '0, '0);
        offer_op(OP_DISPATCH, '0, '0, '0, '0);
        // widest values, then fill the table and overflow it
        offer_op(OP_ADD, '0, '1, '1, '1);
        for (i = 1; i < MAX_TASKS; i++)
            offer_op(OP_ADD, '0, TAG_W'(16'hA000 + i), '0, TIME_W'(i % 3));
        offer_op(OP_ADD, '0, 16'h5A5A, '0, '0);
        offer_op(OP_TICK, '0, '0, '0, '0);
        offer_op(OP_DISPATCH, '0, '0, '0, '0);
        offer_op(OP_DELETE, '0, '0, '0, '0);
        offer_op(OP_DELETE, '0, '0, '0, '0);

        // long receiver hold-off while items keep coming
        long_hold_req = 1'b1;
        for (i = 0; i < RANDOM_OPS / 3; i++)
            offer_random_op();

        send_idle_pct = 52;
        recv_idle_pct = 12;
        for (i = 0; i < RANDOM_OPS / 3; i++)
        begin
            if (i == RANDOM_OPS / 6)
                wait_drained();
            offer_random_op();
        end

        // pending run count saturation on a one-shot task
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_op(OP_DELETE, '0, '0, '0, '0);
        offer_op(OP_ADD, '0, 16'hC3C3, '0, '0);
        for (i = 0; i < SATURATE_TICKS; i++)
            offer_op(OP_TICK, IDX_W'($urandom), TAG_W'($urandom), TIME_W'($urandom),
                     TIME_W'($urandom));
        offer_op(OP_DISPATCH, '0, '0, '0, '0);
        offer_op(OP_DISPATCH, '0, '0, '0, '0);
        for (i = 0; i < RANDOM_OPS - 2 * (RANDOM_OPS / 3); i++)
            offer_random_op();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outcomes_left == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
